FILE: rtl/core/spq_pkg.sv
// Package for the stable priority queue: opcode and status codes, cell control.
// No dependencies; every other file of the block refers to it by scoped name.
package spq_pkg;

    localparam int PRIO_BITS     = 16;
    localparam int WORD_BITS     = 32;
    localparam int OPCODE_BITS   = 2;
    localparam int STATUS_BITS   = 2;
    localparam int MIN_PRIO_BITS = PRIO_BITS + 1;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_PEEK = 2'd2
    } opcode_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Broadcast to every cell of the chain for one transfer
    typedef struct packed {
        logic enq;
        logic deq;
    } cell_ctrl_t;

endpackage

FILE: rtl/core/spq_if.sv
// Handshake interfaces for the request and response channels.
// Depends on spq_pkg for field widths.
interface spq_req_if;
    logic                               valid;
    logic                               ready;
    logic [spq_pkg::OPCODE_BITS-1:0]    opcode;
    logic [spq_pkg::PRIO_BITS-1:0]      priority_req;
    logic [spq_pkg::WORD_BITS-1:0]      payload;

    modport source (output valid, output opcode, output priority_req, output payload,
                    input ready);
    modport sink   (input valid, input opcode, input priority_req, input payload,
                    output ready);
endinterface

interface spq_rsp_if #(
    parameter int COUNT_BITS = 5
);
    logic                                    valid;
    logic                                    ready;
    logic [spq_pkg::STATUS_BITS-1:0]         status;
    logic [spq_pkg::WORD_BITS-1:0]           removed_payload;
    logic                                    head_valid;
    logic [spq_pkg::WORD_BITS-1:0]           head_payload;
    logic signed [spq_pkg::MIN_PRIO_BITS-1:0] min_priority;
    logic [COUNT_BITS-1:0]                   entry_count;

    modport source (output valid, output status, output removed_payload,
                    output head_valid, output head_payload, output min_priority,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input removed_payload,
                    input head_valid, input head_payload, input min_priority,
                    input entry_count, output ready);
endinterface

FILE: rtl/core/spq_cell.sv
// One cell of the sorted chain: holds a single entry and trades it with its
// neighbours on enqueue and dequeue. Depends on spq_pkg.
module spq_cell #(
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  spq_pkg::cell_ctrl_t               ctrl,
    input  logic [spq_pkg::PRIO_BITS-1:0]     new_prio,
    input  logic [PAYLOAD_BITS-1:0]           new_data,
    input  logic                              prev_valid,
    input  logic [spq_pkg::PRIO_BITS-1:0]     prev_prio,
    input  logic [PAYLOAD_BITS-1:0]           prev_data,
    input  logic                              prev_gt,
    input  logic                              next_valid,
    input  logic [spq_pkg::PRIO_BITS-1:0]     next_prio,
    input  logic [PAYLOAD_BITS-1:0]           next_data,
    output logic                              valid,
    output logic [spq_pkg::PRIO_BITS-1:0]     prio,
    output logic [PAYLOAD_BITS-1:0]           data,
    output logic                              gt,
    output logic                              valid_next,
    output logic [spq_pkg::PRIO_BITS-1:0]     prio_next,
    output logic [PAYLOAD_BITS-1:0]           data_next
);

    logic                          valid_reg;
    logic [spq_pkg::PRIO_BITS-1:0] prio_reg;
    logic [PAYLOAD_BITS-1:0]       data_reg;

    // New entry goes behind this cell unless this one is empty or strictly greater
    assign gt = !valid_reg || (prio_reg > new_prio);

    // Next entry: shift down on dequeue, shift up or capture on enqueue
    always_comb
    begin
        valid_next = valid_reg;
        prio_next  = prio_reg;
        data_next  = data_reg;
        priority if (ctrl.deq)
        begin
            valid_next = next_valid;
            prio_next  = next_prio;
            data_next  = next_data;
        end
        else if (ctrl.enq && gt)
        begin
            if (prev_gt)
            begin
                valid_next = prev_valid;
                prio_next  = prev_prio;
                data_next  = prev_data;
            end
            else
            begin
                valid_next = 1'b1;
                prio_next  = new_prio;
                data_next  = new_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Entry contents carry no reset; valid gates every read
    always_ff @(posedge clk)
    begin
        prio_reg <= prio_next;
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign prio  = prio_reg;
    assign data  = data_reg;

endmodule

FILE: rtl/core/stable_priority_queue_top.sv
// Stable priority queue: a chain of DEPTH cells kept in ascending priority order.
// Each response is registered and presented in the cycle after its transfer.
// One request per cycle when not stalled; every cell compares against the new
// priority in parallel and trades its entry with a neighbour in the same cycle.
// Reset: asynchronous, empties the queue and the response register; entry
// contents are not cleared, valid bits gate them.
module stable_priority_queue_top #(
    parameter int DEPTH        = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    spq_req_if.sink     req,
    spq_rsp_if.source   rsp
);

    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam int PB       = spq_pkg::PRIO_BITS;
    localparam int WB       = spq_pkg::WORD_BITS;

    // Chain wiring
    logic                    cell_valid [DEPTH];
    logic [PB-1:0]           cell_prio  [DEPTH];
    logic [PAYLOAD_BITS-1:0] cell_data  [DEPTH];
    logic                    cell_gt    [DEPTH];
    logic                    cell_vnext [DEPTH];
    logic [PB-1:0]           cell_pnext [DEPTH];
    logic [PAYLOAD_BITS-1:0] cell_dnext [DEPTH];
    logic [DEPTH-1:0]        valid_vec;

    logic                    accept;
    logic                    full;
    logic                    empty;
    spq_pkg::opcode_t        op;
    spq_pkg::cell_ctrl_t     ctrl;
    spq_pkg::status_t        status_next;
    logic [PAYLOAD_BITS-1:0] new_data;
    logic [WB-1:0]           head_word;
    logic [WB-1:0]           removed_word;

    logic [CNT_BITS-1:0]     count_reg;
    logic [CNT_BITS-1:0]     count_next;

    logic                    rsp_valid_reg;
    spq_pkg::status_t        status_reg;
    logic [WB-1:0]           removed_reg;
    logic                    head_valid_reg;
    logic [WB-1:0]           head_payload_reg;
    logic signed [spq_pkg::MIN_PRIO_BITS-1:0] min_prio_reg;
    logic [CNT_BITS-1:0]     entry_count_reg;

    // Request transfer when the response slot is free or being drained
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign op        = spq_pkg::opcode_t'(req.opcode);
    assign full      = cell_valid[DEPTH-1];
    assign empty     = !cell_valid[0];

    // Decode; full enqueue and empty dequeue leave the chain alone
    always_comb
    begin
        ctrl.enq    = 1'b0;
        ctrl.deq    = 1'b0;
        status_next = spq_pkg::ST_OK;
        count_next  = count_reg;
        unique case (op)
            spq_pkg::OP_ENQ:
            begin
                if (full)
                begin
                    status_next = spq_pkg::ST_FULL;
                end
                else
                begin
                    ctrl.enq   = accept;
                    count_next = accept ? count_reg + 1'b1 : count_reg;
                end
            end
            spq_pkg::OP_DEQ:
            begin
                if (empty)
                begin
                    status_next = spq_pkg::ST_EMPTY;
                end
                else
                begin
                    ctrl.deq   = accept;
                    count_next = accept ? count_reg - 1'b1 : count_reg;
                end
            end
            default:
            begin
                status_next = spq_pkg::ST_OK;
            end
        endcase
    end

    // Payload width adaption between the ports and the stored entries
    generate
        if (PAYLOAD_BITS > WB)
        begin : g_wide
            assign new_data     = {{(PAYLOAD_BITS - WB){1'b0}}, req.payload};
            assign head_word    = cell_dnext[0][WB-1:0];
            assign removed_word = cell_data[0][WB-1:0];
        end
        else if (PAYLOAD_BITS == WB)
        begin : g_same
            assign new_data     = req.payload;
            assign head_word    = cell_dnext[0];
            assign removed_word = cell_data[0];
        end
        else
        begin : g_narrow
            assign new_data     = req.payload[PAYLOAD_BITS-1:0];
            assign head_word    = {{(WB - PAYLOAD_BITS){1'b0}}, cell_dnext[0]};
            assign removed_word = {{(WB - PAYLOAD_BITS){1'b0}}, cell_data[0]};
        end
    endgenerate

    // Row of cells, each linked to both neighbours
    generate
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_cell
            logic                    p_valid;
            logic [PB-1:0]           p_prio;
            logic [PAYLOAD_BITS-1:0] p_data;
            logic                    p_gt;
            logic                    n_valid;
            logic [PB-1:0]           n_prio;
            logic [PAYLOAD_BITS-1:0] n_data;

            if (i == 0)
            begin : g_first
                assign p_valid = 1'b0;
                assign p_prio  = '0;
                assign p_data  = '0;
                assign p_gt    = 1'b0;
            end
            else
            begin : g_mid_prev
                assign p_valid = cell_valid[i-1];
                assign p_prio  = cell_prio[i-1];
                assign p_data  = cell_data[i-1];
                assign p_gt    = cell_gt[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign n_valid = 1'b0;
                assign n_prio  = '0;
                assign n_data  = '0;
            end
            else
            begin : g_mid_next
                assign n_valid = cell_valid[i+1];
                assign n_prio  = cell_prio[i+1];
                assign n_data  = cell_data[i+1];
            end

            spq_cell #(
                .PAYLOAD_BITS (PAYLOAD_BITS)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .new_prio   (req.priority_req),
                .new_data   (new_data),
                .prev_valid (p_valid),
                .prev_prio  (p_prio),
                .prev_data  (p_data),
                .prev_gt    (p_gt),
                .next_valid (n_valid),
                .next_prio  (n_prio),
                .next_data  (n_data),
                .valid      (cell_valid[i]),
                .prio       (cell_prio[i]),
                .data       (cell_data[i]),
                .gt         (cell_gt[i]),
                .valid_next (cell_vnext[i]),
                .prio_next  (cell_pnext[i]),
                .data_next  (cell_dnext[i])
            );

            assign valid_vec[i] = cell_valid[i];
        end
    endgenerate

    // Occupancy and response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Response payload, captured on each request transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg      <= status_next;
            removed_reg     <= ctrl.deq ? removed_word : '0;
            head_valid_reg  <= cell_vnext[0];
            head_payload_reg <= cell_vnext[0] ? head_word : '0;
            min_prio_reg    <= cell_vnext[0] ? $signed({1'b0, cell_pnext[0]}) : '1;
            entry_count_reg <= count_next;
        end
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.status          = status_reg;
    assign rsp.removed_payload = removed_reg;
    assign rsp.head_valid      = head_valid_reg;
    assign rsp.head_payload    = head_payload_reg;
    assign rsp.min_priority    = min_prio_reg;
    assign rsp.entry_count     = entry_count_reg;

    // Occupied cells always form a contiguous run from the head
    a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + 1'b1)) == '0)
        else $error("occupied cells not contiguous");

    // Counter tracks the occupied cells
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNT_BITS'($countones(valid_vec)))
        else $error("occupancy counter out of step with cells");

    // A good dequeue shrinks the queue by one
    a_deq: assert property (@(posedge clk) disable iff (!rst_n)
        accept && op == spq_pkg::OP_DEQ && !empty |=> count_reg == $past(count_reg) - 1'b1)
        else $error("dequeue did not remove one entry");

    // A full enqueue reports the drop and leaves the count unchanged
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        accept && op == spq_pkg::OP_ENQ && full |=>
            rsp.valid && rsp.status == spq_pkg::ST_FULL && count_reg == $past(count_reg))
        else $error("full enqueue not reported as dropped");

endmodule

FILE: tb/spq_checker.sv
// Checker for the stable priority queue: watches both channels, keeps its own sorted copy
// of the queue and compares every response with the predicted one.
// Depends on spq_pkg and the spq_req_if / spq_rsp_if interfaces.
module spq_checker #(
    parameter int DEPTH      = 16,
    parameter int COUNT_BITS = 5
) (
    input  logic clk,
    input  logic rst_n,
    spq_req_if   req,
    spq_rsp_if   rsp,
    output int   fail_count,
    output int   outstanding,
    output int   checked,
    output int   full_drops,
    output int   empty_deqs,
    output int   deepest_fill
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        spq_pkg::status_t                         status;
        logic [spq_pkg::WORD_BITS-1:0]            removed_payload;
        logic                                     head_valid;
        logic [spq_pkg::WORD_BITS-1:0]            head_payload;
        logic signed [spq_pkg::MIN_PRIO_BITS-1:0] min_priority;
        logic [COUNT_BITS-1:0]                    entry_count;
    } spq_result_t;

    // Shadow copy of the sorted entries
    logic [spq_pkg::PRIO_BITS-1:0] shadow_prio [DEPTH];
    logic [spq_pkg::WORD_BITS-1:0] shadow_data [DEPTH];
    int                            shadow_count;

    spq_result_t awaited_responses [$];
    spq_result_t next_result;
    spq_result_t oldest;
    int          failures;
    int          n_checked;
    int          n_full;
    int          n_empty;
    int          n_deepest;

    // Apply one request to the shadow queue and work out its response
    task automatic apply_request(input logic [spq_pkg::OPCODE_BITS-1:0] op,
                                 input logic [spq_pkg::PRIO_BITS-1:0] prio,
                                 input logic [spq_pkg::WORD_BITS-1:0] data,
                                 output spq_result_t res);
        int pos;
        int i;
        res = '0;
        res.status = spq_pkg::ST_OK;
        case (op)
            spq_pkg::OP_ENQ:
            begin
                if (shadow_count >= DEPTH)
                begin
                    res.status = spq_pkg::ST_FULL;
                end
                else
                begin
                    // insert behind every entry of lower or equal priority
                    pos = 0;
                    while (pos < shadow_count && shadow_prio[pos] <= prio)
                        pos++;
                    for (i = shadow_count; i > pos; i--)
                    begin
                        shadow_prio[i] = shadow_prio[i-1];
                        shadow_data[i] = shadow_data[i-1];
                    end
                    shadow_prio[pos] = prio;
                    shadow_data[pos] = data;
                    shadow_count++;
                end
            end
            spq_pkg::OP_DEQ:
            begin
                if (shadow_count == 0)
                begin
                    res.status = spq_pkg::ST_EMPTY;
                end
                else
                begin
                    res.removed_payload = shadow_data[0];
                    for (i = 0; i + 1 < shadow_count; i++)
                    begin
                        shadow_prio[i] = shadow_prio[i+1];
                        shadow_data[i] = shadow_data[i+1];
                    end
                    shadow_count--;
                end
            end
            default:
            begin
                // peek and the unused code leave the queue alone
            end
        endcase
        if (shadow_count > 0)
        begin
            res.head_valid   = 1'b1;
            res.head_payload = shadow_data[0];
            res.min_priority = {1'b0, shadow_prio[0]};
        end
        else
        begin
            res.head_valid   = 1'b0;
            res.head_payload = '0;
            res.min_priority = '1;
        end
        res.entry_count = shadow_count[COUNT_BITS-1:0];
    endtask

    // Responses are checked before the request of the same edge is predicted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_count = 0;
            awaited_responses.delete();
            failures  = 0;
            n_checked = 0;
            n_full    = 0;
            n_empty   = 0;
            n_deepest = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_responses.size() == 0)
                begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                        $display("%0t: response with nothing awaited: status %0d count %0d",
                                 $realtime, rsp.status, rsp.entry_count);
                end
                else
                begin
                    oldest = awaited_responses.pop_front();
                    n_checked++;
                    if (rsp.status !== oldest.status ||
                        rsp.removed_payload !== oldest.removed_payload ||
                        rsp.head_valid !== oldest.head_valid ||
                        rsp.head_payload !== oldest.head_payload ||
                        rsp.min_priority !== oldest.min_priority ||
                        rsp.entry_count !== oldest.entry_count)
                    begin
                        failures++;
                        if (failures <= REPORT_LIMIT)
                        begin
                            $display("%0t: response mismatch (status removed hv head min count)",
                                     $realtime);
                            $display("  wanted %0d %h %0d %h %0d %0d", oldest.status,
                                     oldest.removed_payload, oldest.head_valid,
                                     oldest.head_payload, oldest.min_priority,
                                     oldest.entry_count);
                            $display("  got    %0d %h %0d %h %0d %0d", rsp.status,
                                     rsp.removed_payload, rsp.head_valid, rsp.head_payload,
                                     $signed(rsp.min_priority), rsp.entry_count);
                        end
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                apply_request(req.opcode, req.priority_req, req.payload, next_result);
                awaited_responses.push_back(next_result);
                if (next_result.status == spq_pkg::ST_FULL)
                    n_full++;
                if (next_result.status == spq_pkg::ST_EMPTY)
                    n_empty++;
                if (shadow_count > n_deepest)
                    n_deepest = shadow_count;
            end
        end
        // outputs move with the edge so that readers see a settled value
        fail_count   <= failures;
        outstanding  <= awaited_responses.size();
        checked      <= n_checked;
        full_drops   <= n_full;
        empty_deqs   <= n_empty;
        deepest_fill <= n_deepest;
    end

endmodule

FILE: tb/stable_priority_queue_top_tb.sv
// Top of the stable priority queue testbench: clock, reset, request and response stimulus.
// Depends on spq_pkg, the channel interfaces, the block and spq_checker.
module stable_priority_queue_top_tb;

    localparam int DEPTH        = 16;
    localparam int COUNT_BITS   = 5;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 4;

    localparam logic [spq_pkg::OPCODE_BITS-1:0] OP_UNUSED = 2'd3;

    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    logic clk = 1'b0;
    logic rst_n;

    int send_idle_pct;
    int recv_idle_pct;
    int requests_sent;

    int fail_count;
    int outstanding;
    int checked;
    int full_drops;
    int empty_deqs;
    int deepest_fill;

    spq_req_if                          req_if ();
    spq_rsp_if #(.COUNT_BITS(COUNT_BITS)) rsp_if ();

    stable_priority_queue_top #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (spq_pkg::WORD_BITS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    spq_checker #(
        .DEPTH      (DEPTH),
        .COUNT_BITS (COUNT_BITS)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req_if),
        .rsp          (rsp_if),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .checked      (checked),
        .full_drops   (full_drops),
        .empty_deqs   (empty_deqs),
        .deepest_fill (deepest_fill)
    );

    always #5 clk = ~clk;

    // Receiver back-pressure
    initial
    begin
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: too long without any transfer on either channel
    initial
    begin
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                stalled = 0;
            else
                stalled++;
        end
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("stable_priority_queue_top_tb failed");
        $finish;
    end

    // One request transfer, with random gaps in front of it
    task automatic send_item(input logic [spq_pkg::OPCODE_BITS-1:0] op,
                             input logic [spq_pkg::PRIO_BITS-1:0] prio,
                             input logic [spq_pkg::WORD_BITS-1:0] data);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid        <= 1'b1;
        req_if.opcode       <= op;
        req_if.priority_req <= prio;
        req_if.payload      <= data;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        requests_sent++;
    endtask

    // Hold the sender off until every response is back
    task automatic wait_until_drained();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Random traffic in runs that fill, drain or mix, so full and empty are both reached
    task automatic run_random_phase(input int n_items);
        int mode;
        int run_left;
        int roll;
        int enq_share;
        int k;
        logic [spq_pkg::OPCODE_BITS-1:0] op;
        logic [spq_pkg::PRIO_BITS-1:0]   prio;
        mode = MODE_MIXED;
        run_left = 0;
        for (k = 0; k < n_items; k++)
        begin
            if (run_left == 0)
            begin
                mode = $urandom_range(MODE_FILL, MODE_MIXED);
                run_left = $urandom_range(24, 60);
            end
            run_left--;
            enq_share = (mode == MODE_FILL) ? 70 : (mode == MODE_DRAIN) ? 25 : 50;
            roll = $urandom_range(0, 99);
            if (roll < 3)
                op = OP_UNUSED;
            else if (roll < 10)
                op = spq_pkg::OP_PEEK;
            else
                op = ($urandom_range(0, 99) < enq_share) ? spq_pkg::OP_ENQ : spq_pkg::OP_DEQ;
            // narrow priorities give plenty of ties
            roll = $urandom_range(0, 9);
            if (roll < 4)
                prio = 16'($urandom_range(0, 7));
            else if (roll == 4)
                prio = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            else
                prio = 16'($urandom);
            send_item(op, prio, $urandom);
        end
    endtask

    initial
    begin
        int i;
        logic [spq_pkg::PRIO_BITS-1:0] p;
        logic [spq_pkg::WORD_BITS-1:0] d;

        rst_n               = 1'b0;
        req_if.valid        <= 1'b0;
        req_if.opcode       <= spq_pkg::OP_PEEK;
        req_if.priority_req <= '0;
        req_if.payload      <= '0;
        send_idle_pct       = 36;
        recv_idle_pct       = 71;
        requests_sent       = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty queue cases, a full fill with ties, overflow, then a drain start
        send_item(spq_pkg::OP_PEEK, 16'h0000, 32'h0000_0000);
        send_item(spq_pkg::OP_DEQ, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(OP_UNUSED, 16'h1234, 32'h5555_AAAA);
        for (i = 0; i < DEPTH; i++)
        begin
            if (i == 0)
            begin
                p = 16'hFFFF;
                d = 32'hFFFF_FFFF;
            end
            else if (i == 1)
            begin
                p = 16'h0000;
                d = 32'h0000_0000;
            end
            else
            begin
                p = (i % 2) ? 16'd5 : 16'(i * 4099);
                d = 32'hA5A5_0000 | 32'(i);
            end
            send_item(spq_pkg::OP_ENQ, p, d);
        end
        send_item(spq_pkg::OP_ENQ, 16'h0000, 32'hDEAD_BEEF);
        send_item(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(spq_pkg::OP_PEEK, 16'h8000, 32'h8000_0000);
        send_item(spq_pkg::OP_DEQ, 16'h0000, 32'h0000_0000);
        send_item(spq_pkg::OP_DEQ, 16'h0000, 32'h0000_0000);
        wait_until_drained();

        // Random: sender idles lightly, receiver heavily
        run_random_phase(340);
        wait_until_drained();

        // Random: the other way round
        send_idle_pct = 71;
        recv_idle_pct = 36;
        run_random_phase(330);
        wait_until_drained();

        // Random: back to back on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase(330);

        req_if.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d requests in three back-pressure phases, %0d responses compared",
                 requests_sent, checked);
        $display("saw %0d drops on a full queue, %0d dequeues on an empty one, deepest fill %0d",
                 full_drops, empty_deqs, deepest_fill);
        if (fail_count == 0 && outstanding == 0)
            $display("stable_priority_queue_top_tb passed");
        else
            $display("stable_priority_queue_top_tb failed");
        $finish;
    end

endmodule
